/* src/dpd_pkg.sv */
`default_nettype none

package dpd_pkg;

   localparam int FULL_SCALE         = 127;
   localparam int GAIN_FRACTION_BITS = 8;

   localparam int POWER_MAX  = 127;
   localparam int RAW_MAX    = 32767;
   // Full-scale limit as seen by the 8 bit power fields
   localparam logic [6:0] FULL_LIMIT = 7'((FULL_SCALE > POWER_MAX) ? POWER_MAX : FULL_SCALE);

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAIN_P        = 3'd0,
      CSR_GAIN_D        = 3'd1,
      CSR_STRAIGHT_MODE = 3'd2,
      CSR_CAP_ENABLE    = 3'd3,
      CSR_POWER_CAP     = 3'd4,
      CSR_RAMP_STEP     = 3'd5,
      CSR_PAUSED        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_d;
      logic        straight_mode;
      logic        cap_enable;
      logic [6:0]  power_cap;
      logic [6:0]  ramp_step;
      logic        paused;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] enc_left;
      logic signed [31:0] enc_right;
      logic signed [20:0] step_left;
      logic signed [20:0] step_right;
      logic               clear_targets;
   } req_type;

   // Current and previous error of each side
   typedef struct packed {
      logic signed [31:0] err_left;
      logic signed [31:0] err_right;
      logic signed [31:0] prev_left;
      logic signed [31:0] prev_right;
   } err_type;

   typedef struct packed {
      logic signed [15:0] raw_left;
      logic signed [15:0] raw_right;
   } raw_type;

   typedef struct packed {
      logic signed [7:0] power_left;
      logic signed [7:0] power_right;
      logic              drive_enable;
   } rsp_type;

   function automatic logic signed [31:0] sat_err(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat_raw(input logic signed [50:0] v);
      logic signed [15:0] r;
      if (v > 51'(RAW_MAX)) begin
         r = 16'(RAW_MAX);
      end else if (v < -51'(RAW_MAX)) begin
         r = -16'(RAW_MAX);
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/dpd_error.sv */
`default_nettype none

module dpd_error (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire dpd_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output dpd_pkg::err_type      out_data
);
   import dpd_pkg::*;

   logic               valid_ff;
   err_type            data_ff;
   logic signed [31:0] target_left_ff, target_left_in;
   logic signed [31:0] target_right_ff, target_right_in;
   logic signed [31:0] last_left_ff;
   logic signed [31:0] last_right_ff;
   logic signed [31:0] err_left, err_right;
   logic               fire;

   assign in_ready = !valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   // targets wrap, the error saturates
   always_comb begin
      target_left_in  = (in_data.clear_targets ? 32'sd0 : target_left_ff)
                        + 32'(in_data.step_left);
      target_right_in = (in_data.clear_targets ? 32'sd0 : target_right_ff)
                        + 32'(in_data.step_right);
      err_left  = sat_err(33'(target_left_in) - 33'(in_data.enc_left));
      err_right = sat_err(33'(target_right_in) - 33'(in_data.enc_right));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         target_left_ff <= '0;
         target_right_ff <= '0;
         last_left_ff   <= '0;
         last_right_ff  <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (fire) begin
            target_left_ff  <= target_left_in;
            target_right_ff <= target_right_in;
            last_left_ff    <= err_left;
            last_right_ff   <= err_right;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff.err_left   <= err_left;
         data_ff.err_right  <= err_right;
         data_ff.prev_left  <= last_left_ff;
         data_ff.prev_right <= last_right_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* src/dpd_gain.sv */
`default_nettype none

module dpd_gain (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dpd_pkg::cfg_type cfg,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire dpd_pkg::err_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output dpd_pkg::raw_type      out_data
);
   import dpd_pkg::*;

   // difference stage
   logic               v2_ff;
   logic signed [31:0] e_left_ff, e_right_ff;
   logic signed [32:0] d_left_ff, d_right_ff, sum_ff;
   // product stage
   logic               v3_ff;
   logic signed [48:0] pp_left_ff, pp_right_ff;
   logic signed [49:0] pd_left_ff, pd_right_ff, pc_ff;
   logic               pos_left_ff, pos_right_ff;
   // raw power stage
   logic               v4_ff;
   raw_type            raw_ff;

   logic               rdy2, rdy3, rdy4;
   logic signed [16:0] gain_p_s, gain_d_s;
   logic signed [48:0] pp_left, pp_right;
   logic signed [49:0] pd_left, pd_right, pc;
   logic signed [50:0] s_left, s_right, comb_sum;
   logic signed [15:0] raw_l, raw_r, comb_raw;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;

   assign gain_p_s = $signed({1'b0, cfg.gain_p});
   assign gain_d_s = $signed({1'b0, cfg.gain_d});

   always_comb begin
      pp_left  = gain_p_s * e_left_ff;
      pp_right = gain_p_s * e_right_ff;
      pd_left  = gain_d_s * d_left_ff;
      pd_right = gain_d_s * d_right_ff;
      pc       = gain_p_s * sum_ff;
   end

   // arithmetic shifts round toward minus infinity
   always_comb begin
      s_left   = (51'(pp_left_ff) + 51'(pd_left_ff)) >>> GAIN_FRACTION_BITS;
      s_right  = (51'(pp_right_ff) + 51'(pd_right_ff)) >>> GAIN_FRACTION_BITS;
      comb_sum = 51'(pc_ff) >>> (GAIN_FRACTION_BITS + 1);
      comb_raw = sat_raw(comb_sum);
      if (cfg.straight_mode) begin
         raw_l = pos_left_ff ? comb_raw : -comb_raw;
         raw_r = pos_right_ff ? comb_raw : -comb_raw;
      end else begin
         raw_l = sat_raw(s_left);
         raw_r = sat_raw(s_right);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            v2_ff <= in_valid;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && in_valid) begin
         e_left_ff  <= in_data.err_left;
         e_right_ff <= in_data.err_right;
         d_left_ff  <= 33'(in_data.err_left) - 33'(in_data.prev_left);
         d_right_ff <= 33'(in_data.err_right) - 33'(in_data.prev_right);
         sum_ff     <= 33'(in_data.err_left) + 33'(in_data.err_right);
      end
      if (rdy3 && v2_ff) begin
         pp_left_ff   <= pp_left;
         pp_right_ff  <= pp_right;
         pd_left_ff   <= pd_left;
         pd_right_ff  <= pd_right;
         pc_ff        <= pc;
         pos_left_ff  <= !e_left_ff[31] && (e_left_ff != 32'sd0);
         pos_right_ff <= !e_right_ff[31] && (e_right_ff != 32'sd0);
      end
      if (rdy4 && v3_ff) begin
         raw_ff.raw_left  <= raw_l;
         raw_ff.raw_right <= raw_r;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = raw_ff;

endmodule

`default_nettype wire

/* src/dpd_ramp.sv */
`default_nettype none

module dpd_ramp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dpd_pkg::cfg_type cfg,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire dpd_pkg::raw_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output dpd_pkg::rsp_type      out_data
);
   import dpd_pkg::*;

   logic              valid_ff;
   rsp_type           data_ff;
   logic signed [7:0] held_left_ff, held_left_in;
   logic signed [7:0] held_right_ff, held_right_in;
   logic [6:0]        lim;
   logic              fire;

   function automatic logic signed [7:0] ramp_cap(input logic signed [7:0]  held,
                                                  input logic signed [15:0] raw,
                                                  input logic [6:0]         step,
                                                  input logic [6:0]         limit);
      logic signed [16:0] delta, r, l, p;
      delta = 17'(raw) - 17'(held);
      r     = $signed({10'b0, step});
      l     = $signed({10'b0, limit});
      if (delta > r) begin
         p = 17'(held) + r;
      end else if (delta < -r) begin
         p = 17'(held) - r;
      end else begin
         p = 17'(raw);
      end
      if (p > l) begin
         p = l;
      end else if (p < -l) begin
         p = -l;
      end
      return p[7:0];
   endfunction

   assign in_ready = !valid_ff || out_ready;
   assign fire     = in_valid && in_ready;
   assign lim      = cfg.cap_enable ? cfg.power_cap : FULL_LIMIT;

   always_comb begin
      held_left_in  = ramp_cap(held_left_ff, in_data.raw_left, cfg.ramp_step, lim);
      held_right_in = ramp_cap(held_right_ff, in_data.raw_right, cfg.ramp_step, lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (fire) begin
            held_left_ff  <= held_left_in;
            held_right_ff <= held_right_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff.power_left   <= held_left_in;
         data_ff.power_right  <= held_right_in;
         data_ff.drive_enable <= !cfg.paused;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* src/dual_pd_drive_with_slew_limit.sv */
`default_nettype none
// Two-sided PD drive with slew limit.
// req channel: one transfer per control tick carrying both encoder
//   positions, the target increments and the clear flag. The block keeps the
//   position targets, last errors and held powers itself.
// rsp channel: exactly one transfer per request, in order, with the ramped
//   and capped left/right powers and the drive enable.
// csr port: write-only registers (gains, straight mode, cap, ramp step,
//   pause), to be written while no request is in flight; the block does not enforce it.
// Datapath: an input register and five stages (target/error, error
//   difference, gain multipliers, shift and saturate, ramp and cap), so one
//   request is taken per cycle while rsp is not stalled; each state update
//   sits inside one stage.
// Reset: synchronous; clears targets, last errors, held powers and all stage
//   valids, and loads the register defaults.
// Stall: a held result stays on rsp while the stages behind it keep filling;
//   req_tready drops only once every stage holds a request.
module dual_pd_drive_with_slew_limit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // enc_left, enc_right, step_left, step_right, clear_targets, zero pad
   input  wire logic [dpd_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // power_left, power_right, drive_enable, zero pad
   output logic [dpd_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [dpd_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [dpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import dpd_pkg::*;

   cfg_type cfg_ff;
   logic    s0_valid_ff;
   req_type s0_data_ff, s0_data_in;

   logic    err_ready, err_valid;
   err_type err_data;
   logic    gain_ready, gain_valid;
   raw_type raw_data;
   logic    ramp_ready;
   rsp_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p        <= 16'd256;
         cfg_ff.gain_d        <= 16'd0;
         cfg_ff.straight_mode <= 1'b0;
         cfg_ff.cap_enable    <= 1'b0;
         cfg_ff.power_cap     <= 7'd127;
         cfg_ff.ramp_step     <= 7'd10;
         cfg_ff.paused        <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_GAIN_P:        cfg_ff.gain_p        <= csr_wdata;
            CSR_GAIN_D:        cfg_ff.gain_d        <= csr_wdata;
            CSR_STRAIGHT_MODE: cfg_ff.straight_mode <= csr_wdata[0];
            CSR_CAP_ENABLE:    cfg_ff.cap_enable    <= csr_wdata[0];
            CSR_POWER_CAP:     cfg_ff.power_cap     <= csr_wdata[6:0];
            CSR_RAMP_STEP:     cfg_ff.ramp_step     <= csr_wdata[6:0];
            CSR_PAUSED:        cfg_ff.paused        <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s0_data_in.enc_left      = req_tdata[31:0];
      s0_data_in.enc_right     = req_tdata[63:32];
      s0_data_in.step_left     = req_tdata[84:64];
      s0_data_in.step_right    = req_tdata[105:85];
      s0_data_in.clear_targets = req_tdata[106];
   end

   assign req_tready = !s0_valid_ff || err_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s0_data_ff <= s0_data_in;
      end
   end

   dpd_error u_error (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_ready  (err_ready),
      .in_data   (s0_data_ff),
      .out_valid (err_valid),
      .out_ready (gain_ready),
      .out_data  (err_data)
   );

   dpd_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (err_valid),
      .in_ready  (gain_ready),
      .in_data   (err_data),
      .out_valid (gain_valid),
      .out_ready (ramp_ready),
      .out_data  (raw_data)
   );

   dpd_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (gain_valid),
      .in_ready  (ramp_ready),
      .in_data   (raw_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {7'b0, rsp_data.drive_enable, rsp_data.power_right,
                       rsp_data.power_left};

   logic signed [8:0] lim_s;
   assign lim_s = $signed({2'b0, cfg_ff.cap_enable ? cfg_ff.power_cap : FULL_LIMIT});

   // powers never leave the active limit
   a_power_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (9'(rsp_data.power_left) <= lim_s) && (9'(rsp_data.power_left) >= -lim_s)
                  && (9'(rsp_data.power_right) <= lim_s)
                  && (9'(rsp_data.power_right) >= -lim_s))
      else $error("power outside limit");

   a_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $stable(cfg_ff.paused) |-> rsp_data.drive_enable == !cfg_ff.paused)
      else $error("drive enable does not follow pause");

   // backpressure on req only when the input stage is occupied
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s0_valid_ff && !err_ready)
      else $error("req stalled with free input stage");

   // a pending result is never overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_data))
      else $error("result lost while stalled");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
   import dpd_pkg::*;

   // Predicts each tick of the drive and holds the powers still to come out.
   class drive_scoreboard;
      localparam longint ERR_MIN = -(longint'(1) <<< 31);
      localparam longint ERR_MAX = (longint'(1) <<< 31) - 1;

      logic [15:0]        gain_p = 16'd256;
      logic [15:0]        gain_d = 16'd0;
      bit                 straight = 1'b0;
      bit                 cap_en = 1'b0;
      logic [6:0]         power_cap = 7'd127;
      logic [6:0]         ramp_step = 7'd10;
      bit                 paused = 1'b0;

      logic [31:0]        tgt_l = '0;
      logic [31:0]        tgt_r = '0;
      logic signed [31:0] last_l = '0;
      logic signed [31:0] last_r = '0;
      logic signed [7:0]  held_l = '0;
      logic signed [7:0]  held_r = '0;

      rsp_type            pending[$];
      int                 errors = 0;
      int                 checked = 0;

      function void write_reg(csr_index_type idx, logic [15:0] v);
         case (idx)
            CSR_GAIN_P:        gain_p = v;
            CSR_GAIN_D:        gain_d = v;
            CSR_STRAIGHT_MODE: straight = v[0];
            CSR_CAP_ENABLE:    cap_en = v[0];
            CSR_POWER_CAP:     power_cap = v[6:0];
            CSR_RAMP_STEP:     ramp_step = v[6:0];
            CSR_PAUSED:        paused = v[0];
            default:           ;
         endcase
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function longint slew(longint held, longint raw, longint lim);
         longint r;
         longint p;
         r = ramp_step;
         if (raw - held > r) begin
            p = held + r;
         end else if (raw - held < -r) begin
            p = held - r;
         end else begin
            p = raw;
         end
         return clamp(p, -lim, lim);
      endfunction

      function void note_input(req_type it);
         longint  el, er, gp, gd, rl, rr, comb, lim;
         rsp_type exp;
         if (it.clear_targets) begin
            tgt_l = '0;
            tgt_r = '0;
         end
         tgt_l = tgt_l + {{11{it.step_left[20]}}, it.step_left};
         tgt_r = tgt_r + {{11{it.step_right[20]}}, it.step_right};
         el = clamp(longint'($signed(tgt_l)) - longint'(it.enc_left), ERR_MIN, ERR_MAX);
         er = clamp(longint'($signed(tgt_r)) - longint'(it.enc_right), ERR_MIN, ERR_MAX);
         gp = gain_p;
         gd = gain_d;
         if (!straight) begin
            rl = clamp((gp * el + gd * (el - longint'(last_l))) >>> GAIN_FRACTION_BITS,
                       -32767, 32767);
            rr = clamp((gp * er + gd * (er - longint'(last_r))) >>> GAIN_FRACTION_BITS,
                       -32767, 32767);
         end else begin
            comb = clamp(((el + er) * gp) >>> (GAIN_FRACTION_BITS + 1), -32767, 32767);
            rl = (el > 0) ? comb : -comb;
            rr = (er > 0) ? comb : -comb;
         end
         last_l = 32'(el);
         last_r = 32'(er);
         lim = cap_en ? longint'(power_cap) : longint'(FULL_SCALE);
         lim = clamp(lim, 0, 127);
         held_l = 8'(slew(held_l, rl, lim));
         held_r = 8'(slew(held_r, rr, lim));
         exp.power_left = held_l;
         exp.power_right = held_r;
         exp.drive_enable = !paused;
         pending.push_back(exp);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] d);
         rsp_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result transfer %h", $time, d);
            errors++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if ($signed(d[7:0]) !== exp.power_left) begin
            $display("%0t: power_left expected %0d actual %0d",
                     $time, exp.power_left, $signed(d[7:0]));
            errors++;
         end
         if ($signed(d[15:8]) !== exp.power_right) begin
            $display("%0t: power_right expected %0d actual %0d",
                     $time, exp.power_right, $signed(d[15:8]));
            errors++;
         end
         if (d[16] !== exp.drive_enable) begin
            $display("%0t: drive_enable expected %0b actual %0b",
                     $time, exp.drive_enable, d[16]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   drive_scoreboard sb = new();
   bit              quiet = 1'b0;
   bit              hold_start = 1'b0;
   int              sent = 0;
   int              settings = 1;

   dual_pd_drive_with_slew_limit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   initial begin
      #200000;
      $display("tb: FAIL");
      $finish;
   end

   // Result side: random backpressure, plus a counted hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 35);
         end
      end
   end

   function automatic req_type mk(logic [31:0] el, logic [31:0] er,
                                  logic [20:0] sl, logic [20:0] sr, logic clr);
      req_type it;
      it.enc_left = el;
      it.enc_right = er;
      it.step_left = sl;
      it.step_right = sr;
      it.clear_targets = clr;
      return it;
   endfunction

   function automatic logic [20:0] rand_step();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return 21'(int'($urandom_range(400)) - 200);
      if (pick < 90) return 21'($urandom());
      return $urandom_range(1) ? 21'h100000 : 21'h0fffff;
   endfunction

   // Mostly positions close to the target so the loop stays out of saturation.
   function automatic logic [31:0] rand_pos(logic [31:0] t);
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) return t + 32'(int'($urandom_range(300)) - 150);
      if (pick < 90) return $urandom();
      return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
   endfunction

   function automatic req_type rand_item();
      req_type     it;
      logic [31:0] base_l, base_r;
      it.clear_targets = ($urandom_range(99) < 8);
      it.step_left = rand_step();
      it.step_right = rand_step();
      base_l = it.clear_targets ? 32'd0 : sb.tgt_l;
      base_r = it.clear_targets ? 32'd0 : sb.tgt_r;
      it.enc_left = rand_pos(base_l + {{11{it.step_left[20]}}, it.step_left});
      it.enc_right = rand_pos(base_r + {{11{it.step_right[20]}}, it.step_right});
      return it;
   endfunction

   task automatic send_item(req_type it);
      while (!quiet && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, it.clear_targets, it.step_right, it.step_left,
                    it.enc_right, it.enc_left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(it);
      sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_reg(csr_index_type idx, logic [15:0] v);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, v);
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_gain();
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) return 16'd0;
      if (pick < 24) return 16'hffff;
      if (pick < 80) return 16'($urandom_range(1023));
      return 16'($urandom());
   endfunction

   task automatic random_config();
      int pick;
      set_reg(CSR_GAIN_P, rand_gain());
      set_reg(CSR_GAIN_D, ($urandom_range(1)) ? rand_gain() : 16'd0);
      set_reg(CSR_STRAIGHT_MODE, 16'($urandom_range(99) < 30));
      set_reg(CSR_CAP_ENABLE, 16'($urandom_range(1)));
      pick = $urandom_range(99);
      set_reg(CSR_POWER_CAP, (pick < 15) ? 16'd0 : (pick < 30) ? 16'd127
                             : 16'($urandom_range(127)));
      pick = $urandom_range(99);
      set_reg(CSR_RAMP_STEP, (pick < 15) ? 16'd1 : (pick < 30) ? 16'd127
                             : 16'($urandom_range(127, 1)));
      set_reg(CSR_PAUSED, 16'($urandom_range(99) < 25));
      settings++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset settings: extremes of positions and steps, error saturation,
      // target accumulation and clearing.
      send_item(mk(0, 0, 0, 0, 0));
      send_item(mk(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0));
      send_item(mk(0, 0, 21'h0fffff, 21'h100000, 0));
      send_item(mk(0, 0, 21'h0fffff, 21'h100000, 0));
      send_item(mk(32'h7fff_ffff, 32'h8000_0000, 21'h100000, 21'h0fffff, 1));
      send_item(mk(-32'sd50, 32'sd30, 0, 0, 1));
      wait_idle();

      // Largest gains and ramp step: raw power saturation.
      set_reg(CSR_GAIN_P, 16'hffff);
      set_reg(CSR_GAIN_D, 16'hffff);
      set_reg(CSR_RAMP_STEP, 16'd127);
      settings++;
      send_item(mk(-32'sd100000, 32'sd100000, 0, 0, 1));
      send_item(mk(32'sd100000, -32'sd100000, 0, 0, 1));
      send_item(mk(0, 0, 0, 0, 1));
      wait_idle();

      // Straight mode: mixed signs, a zero error, saturated errors.
      set_reg(CSR_STRAIGHT_MODE, 16'd1);
      set_reg(CSR_GAIN_D, 16'd0);
      set_reg(CSR_GAIN_P, 16'd256);
      settings++;
      send_item(mk(-32'sd40, 32'sd20, 0, 0, 1));
      send_item(mk(0, -32'sd300, 0, 0, 1));
      send_item(mk(-32'sd7, -32'sd9, 0, 0, 1));
      send_item(mk(32'h8000_0000, 32'h8000_0000, 0, 0, 1));
      wait_idle();

      // Cap of zero forces both powers to zero.
      set_reg(CSR_STRAIGHT_MODE, 16'd0);
      set_reg(CSR_CAP_ENABLE, 16'd1);
      set_reg(CSR_POWER_CAP, 16'd0);
      settings++;
      send_item(mk(-32'sd500, 32'sd500, 0, 0, 1));
      send_item(mk(0, 0, 21'd3, -21'sd3, 0));
      wait_idle();

      // Zero ramp step while paused: held power never moves.
      set_reg(CSR_POWER_CAP, 16'd127);
      set_reg(CSR_RAMP_STEP, 16'd0);
      set_reg(CSR_PAUSED, 16'd1);
      settings++;
      send_item(mk(-32'sd20, 32'sd20, 0, 0, 1));
      send_item(mk(0, 0, 0, 0, 1));
      wait_idle();

      // Smallest ramp step, full scale, running again.
      set_reg(CSR_RAMP_STEP, 16'd1);
      set_reg(CSR_PAUSED, 16'd0);
      set_reg(CSR_CAP_ENABLE, 16'd0);
      settings++;
      send_item(mk(-32'sd300, 32'sd300, 0, 0, 1));
      send_item(mk(-32'sd300, 32'sd300, 0, 0, 1));
      send_item(mk(32'sd300, -32'sd300, 0, 0, 1));
      wait_idle();

      for (int ph = 0; ph < 10; ph++) begin
         random_config();
         quiet = (ph == 3) || (ph == 6);
         if (ph == 6) hold_start = 1'b1;
         for (int n = 0; n < 130; n++) send_item(rand_item());
         wait_idle();
      end
      quiet = 1'b0;

      $display("tb: %0d requests sent, %0d results checked under %0d register settings",
               sent, sb.checked, settings);
      $display("tb: covered saturation, zero cap, zero ramp, straight mode, pause, stalls");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
